/* sv/lcrs_pkg.sv */
// ----------------------------------------------------------------------------
// lcrs_pkg: shared constants, types and fixed-point helpers
// Weight layout, register indexes, issue kinds, state codes and the PWL activation curves.
// ----------------------------------------------------------------------------
package lcrs_pkg;

   localparam int HID      = 32;
   localparam int HID_W    = 5;
   localparam int GATES    = 4 * HID;
   localparam int GATE_W   = 7;
   localparam int FEAT     = 3;
   localparam int FEAT_W   = 2;
   localparam int WWORDS   = 8192;
   localparam int WADDR_W  = 13;
   localparam int COL_W    = 6;
   localparam int CSR_N    = 8;
   localparam int CSR_W    = 3;
   localparam int ACC_W    = 40;
   localparam int SUB_W    = 4;

   localparam int BASE_WHH = 0;
   localparam int BASE_WIH = BASE_WHH + GATES * HID;
   localparam int BASE_BIH = BASE_WIH + GATES * FEAT;
   localparam int BASE_BHH = BASE_BIH + GATES;
   localparam int BASE_FCW = BASE_BHH + GATES;
   localparam int BASE_FCB = BASE_FCW + HID;

   localparam int LAST_GCOL = 2 + FEAT + HID - 1;

   // register indexes
   localparam logic [CSR_W-1:0] R_ACCEL_MEAN  = 3'd0;
   localparam logic [CSR_W-1:0] R_ACCEL_INV   = 3'd1;
   localparam logic [CSR_W-1:0] R_SPEED_MEAN  = 3'd2;
   localparam logic [CSR_W-1:0] R_SPEED_INV   = 3'd3;
   localparam logic [CSR_W-1:0] R_ANGLE_MEAN  = 3'd4;
   localparam logic [CSR_W-1:0] R_ANGLE_INV   = 3'd5;
   localparam logic [CSR_W-1:0] R_OUT_SCALE   = 3'd6;
   localparam logic [CSR_W-1:0] R_OUT_OFFSET  = 3'd7;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // update sub-steps
   localparam logic [SUB_W-1:0] U_ACT  = 4'd5;
   localparam logic [SUB_W-1:0] U_MUL  = 4'd6;
   localparam logic [SUB_W-1:0] U_CELL = 4'd7;
   localparam logic [SUB_W-1:0] U_TANH = 4'd8;
   localparam logic [SUB_W-1:0] U_OMUL = 4'd9;
   localparam logic [SUB_W-1:0] U_WB   = 4'd10;

   typedef enum logic [2:0] {
      K_BIAS_I = 3'd0,
      K_BIAS_H = 3'd1,
      K_FCB    = 3'd2,
      K_MAC_X  = 3'd3,
      K_MAC_H  = 3'd4
   } kind_type;

   typedef struct packed {
      logic              vld;
      kind_type          kind;
      logic              last;
      logic [GATE_W-1:0] row;
      logic [FEAT_W-1:0] xsel;
   } tag_type;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_NORM   = 9'b000000010,
      S_GATE   = 9'b000000100,
      S_GDRAIN = 9'b000001000,
      S_UPD    = 9'b000010000,
      S_FC     = 9'b000100000,
      S_FDRAIN = 9'b001000000,
      S_DENORM = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767)
         return 16'sh7fff;
      else if (v < -64'sd32768)
         return 16'sh8000;
      else
         return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return 32'sh7fffffff;
      else if (v < -64'sd2147483648)
         return 32'sh80000000;
      else
         return v[31:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat40(input logic signed [63:0] v);
      if (v > 64'sd549755813887)
         return 40'sh7fffffffff;
      else if (v < -64'sd549755813888)
         return 40'sh8000000000;
      else
         return v[ACC_W-1:0];
   endfunction

   function automatic logic signed [15:0] to_q12(input logic signed [63:0] v);
      return sat16(v >>> 12);
   endfunction

   // sigmoid of a non-negative Q6.12 magnitude, result in [2048,4096]
   function automatic logic [12:0] sig_pos(input logic [17:0] a);
      if (a >= 18'd20480)
         return 13'd4096;
      else if (a >= 18'd9728)
         return 13'(a >> 5) + 13'd3456;
      else if (a >= 18'd4096)
         return 13'(a >> 3) + 13'd2560;
      else
         return 13'(a >> 2) + 13'd2048;
   endfunction

   function automatic logic [17:0] mag(input logic signed [15:0] x);
      logic signed [17:0] xe;
      xe = 18'(x);
      return x[15] ? 18'(-xe) : 18'(xe);
   endfunction

   function automatic logic signed [15:0] pwl_sig(input logic signed [15:0] x);
      logic [12:0] y;
      y = sig_pos(mag(x));
      return x[15] ? signed'(16'(13'd4096 - y)) : signed'(16'(y));
   endfunction

   function automatic logic signed [15:0] pwl_tanh(input logic signed [15:0] x);
      logic [12:0]        y;
      logic [13:0]        t;
      logic signed [15:0] ts;
      y  = sig_pos(18'(mag(x) << 1));
      t  = {y, 1'b0} - 14'd4096;
      ts = signed'(16'(t));
      return x[15] ? -ts : ts;
   endfunction

endpackage

/* sv/lcrs_ram.sv */
// ----------------------------------------------------------------------------
// lcrs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lcrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/lstm_cell_regressor_step_top.sv */
// ----------------------------------------------------------------------------
// lstm_cell_regressor_step_top: 32-unit LSTM regressor, one time step per beat
// Weight RAM, gate scratch RAM and hidden/cell state RAM around one MAC lane.
// ----------------------------------------------------------------------------
// A load beat (op 0) writes one weight word. A step beat runs through
// normalising, then 128 gate rows of 37 weight reads each (one read and one
// MAC a cycle through the single weight RAM read port), then a drain, the
// cell update for each hidden unit, the dense output and its drain, and
// denormalising, before its prediction appears. The weight RAM is not
// cleared; reading a word never loaded gives an undefined prediction. Hidden
// and cell state read as zero until the first step has written them. A new
// beat is taken only when the block is idle; a finished prediction may wait
// on rsp_ready meanwhile.
module lstm_cell_regressor_step_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_op,
   input  logic [lcrs_pkg::WADDR_W-1:0]       req_weight_index,
   input  logic signed [15:0]                 req_weight_value,
   input  logic signed [31:0]                 req_accel_in,
   input  logic signed [31:0]                 req_speed_in,
   input  logic signed [31:0]                 req_angle_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_prediction,
   input  logic                               csr_we,
   input  logic [lcrs_pkg::CSR_W-1:0]         csr_index,
   input  logic [31:0]                        csr_wdata
);
   import lcrs_pkg::*;

   state_type               state_ff, state_in;
   logic [SUB_W-1:0]        sub_ff;
   logic [FEAT_W-1:0]       feat_ff;
   logic [GATE_W-1:0]       row_ff;
   logic [COL_W-1:0]        col_ff;
   logic [HID_W-1:0]        k_ff;
   logic                    filled_ff;
   logic                    rsp_valid_ff;
   tag_type                 t1_ff, t2_ff, issue;

   logic signed [31:0]      csr_ff [CSR_N];
   logic signed [31:0]      samp_ff [FEAT];
   logic signed [15:0]      x_ff [FEAT];
   logic signed [31:0]      d_ff;
   logic signed [63:0]      nprod_ff;
   logic signed [15:0]      gr_ff [4];
   logic signed [15:0]      act_ff [4];
   logic signed [15:0]      c_old_ff, c_new_ff, th_ff;
   logic signed [31:0]      m1_ff, m2_ff, m3_ff;
   logic signed [31:0]      p2_ff;
   logic signed [16:0]      bsum_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [63:0]      oprod_ff;
   logic signed [31:0]      res_ff, rsp_pred_ff;

   logic                    req_acc, wt_we, gate_we, st_we;
   logic [WADDR_W-1:0]      w_raddr;
   logic [HID_W-1:0]        s_raddr;
   logic signed [15:0]      w_rdata, g_rdata, g_wdata, h_new;
   logic [31:0]             s_rdata;
   logic signed [15:0]      hid_op, opnd;
   logic signed [17:0]      bias_sum;
   logic [CSR_W-1:0]        mean_idx;
   logic [1:0]              gsel;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign wt_we     = req_acc && (req_op == OP_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign mean_idx  = {feat_ff, 1'b0};
   assign gsel      = 2'(sub_ff - 4'd1);

   // ---------------- weight read sequencer ----------------
   always_comb begin
      issue   = '0;
      w_raddr = '0;
      s_raddr = k_ff;
      if (state_ff == S_GATE) begin
         issue.vld  = 1'b1;
         issue.row  = row_ff;
         issue.last = (col_ff == COL_W'(LAST_GCOL));
         if (col_ff == '0) begin
            issue.kind = K_BIAS_I;
            w_raddr    = WADDR_W'(BASE_BIH) + WADDR_W'(row_ff);
         end else if (col_ff == COL_W'(1)) begin
            issue.kind = K_BIAS_H;
            w_raddr    = WADDR_W'(BASE_BHH) + WADDR_W'(row_ff);
         end else if (col_ff < COL_W'(2 + FEAT)) begin
            issue.kind = K_MAC_X;
            issue.xsel = FEAT_W'(col_ff - COL_W'(2));
            w_raddr    = WADDR_W'(BASE_WIH) + WADDR_W'(row_ff) * WADDR_W'(FEAT)
                         + WADDR_W'(col_ff - COL_W'(2));
         end else begin
            issue.kind = K_MAC_H;
            s_raddr    = HID_W'(col_ff - COL_W'(2 + FEAT));
            w_raddr    = WADDR_W'(BASE_WHH) + WADDR_W'(row_ff) * WADDR_W'(HID)
                         + WADDR_W'(col_ff - COL_W'(2 + FEAT));
         end
      end else if (state_ff == S_FC) begin
         issue.vld = 1'b1;
         if (col_ff == '0) begin
            issue.kind = K_FCB;
            w_raddr    = WADDR_W'(BASE_FCB);
         end else begin
            issue.kind = K_MAC_H;
            s_raddr    = HID_W'(col_ff - COL_W'(1));
            w_raddr    = WADDR_W'(BASE_FCW) + WADDR_W'(col_ff - COL_W'(1));
         end
      end
   end

   // ---------------- MAC lane ----------------
   assign hid_op = filled_ff ? signed'(s_rdata[15:0]) : 16'sd0;
   assign opnd   = (t1_ff.kind == K_MAC_X) ? x_ff[t1_ff.xsel] : hid_op;
   assign bias_sum = 18'(bsum_ff) + 18'(p2_ff);

   always_comb begin
      case (t2_ff.kind)
         K_BIAS_H: acc_in = ACC_W'(bias_sum) <<< 12;
         K_FCB:    acc_in = ACC_W'(p2_ff) <<< 12;
         K_MAC_X,
         K_MAC_H:  acc_in = sat40(64'(acc_ff) + 64'(p2_ff));
         default:  acc_in = acc_ff;
      endcase
   end

   assign gate_we = t2_ff.vld && t2_ff.last;
   assign g_wdata = to_q12(64'(acc_in));

   // ---------------- cell update write-back ----------------
   assign h_new = to_q12(64'(m3_ff));
   assign st_we = (state_ff == S_UPD) && (sub_ff == U_WB);

   lcrs_ram #(.WIDTH(16), .DEPTH(WWORDS)) u_wram (
      .clock (clock),
      .we    (wt_we),
      .waddr (req_weight_index),
      .wdata (req_weight_value),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   lcrs_ram #(.WIDTH(16), .DEPTH(GATES)) u_gram (
      .clock (clock),
      .we    (gate_we),
      .waddr (t2_ff.row),
      .wdata (g_wdata),
      .raddr ({sub_ff[1:0], k_ff}),
      .rdata (g_rdata)
   );

   // state word: cell in the upper half, hidden in the lower
   lcrs_ram #(.WIDTH(32), .DEPTH(HID)) u_sram (
      .clock (clock),
      .we    (st_we),
      .waddr (k_ff),
      .wdata ({c_new_ff, h_new}),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_acc && req_op == OP_STEP) state_in = S_NORM;
         S_NORM:   if (sub_ff == 4'd2 && feat_ff == FEAT_W'(FEAT - 1)) state_in = S_GATE;
         S_GATE:   if (col_ff == COL_W'(LAST_GCOL) && row_ff == GATE_W'(GATES - 1))
                      state_in = S_GDRAIN;
         S_GDRAIN: if (!t1_ff.vld && !t2_ff.vld) state_in = S_UPD;
         S_UPD:    if (sub_ff == U_WB && k_ff == HID_W'(HID - 1)) state_in = S_FC;
         S_FC:     if (col_ff == COL_W'(HID)) state_in = S_FDRAIN;
         S_FDRAIN: if (!t1_ff.vld && !t2_ff.vld) state_in = S_DENORM;
         S_DENORM: if (sub_ff == 4'd1) state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sub_ff       <= '0;
         feat_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         filled_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         t1_ff        <= '0;
         t2_ff        <= '0;
         for (int i = 0; i < CSR_N; i++) begin
            csr_ff[i] <= ((i % 2) == 1 && i != CSR_N - 1) ? 32'sd65536 : 32'sd0;
         end
      end else begin
         state_ff <= state_in;
         t1_ff    <= issue;
         t2_ff    <= t1_ff;
         if (csr_we) begin
            csr_ff[csr_index] <= signed'(csr_wdata);
         end
         if (state_ff != state_in) begin
            sub_ff <= '0;
            col_ff <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               feat_ff <= '0;
               row_ff  <= '0;
               k_ff    <= '0;
            end
            S_NORM: begin
               if (sub_ff == 4'd2) begin
                  sub_ff  <= '0;
                  feat_ff <= feat_ff + FEAT_W'(1);
               end else begin
                  sub_ff <= sub_ff + SUB_W'(1);
               end
            end
            S_GATE: begin
               if (col_ff == COL_W'(LAST_GCOL)) begin
                  col_ff <= '0;
                  row_ff <= row_ff + GATE_W'(1);
               end else begin
                  col_ff <= col_ff + COL_W'(1);
               end
            end
            S_UPD: begin
               if (sub_ff == U_WB) begin
                  sub_ff <= '0;
                  k_ff   <= k_ff + HID_W'(1);
                  if (k_ff == HID_W'(HID - 1)) begin
                     filled_ff <= 1'b1;
                  end
               end else begin
                  sub_ff <= sub_ff + SUB_W'(1);
               end
            end
            S_FC: begin
               if (state_in == S_FC) col_ff <= col_ff + COL_W'(1);
            end
            S_DENORM: begin
               if (state_in == S_DENORM) sub_ff <= sub_ff + SUB_W'(1);
            end
            default: ;
         endcase
         if (state_ff == S_OUT && state_in == S_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (req_acc) begin
         samp_ff[0] <= req_accel_in;
         samp_ff[1] <= req_speed_in;
         samp_ff[2] <= req_angle_in;
      end
      if (state_ff == S_NORM) begin
         case (sub_ff)
            4'd0:    d_ff <= sat32(64'(samp_ff[feat_ff]) - 64'(csr_ff[mean_idx]));
            4'd1:    nprod_ff <= 64'(d_ff) * 64'(csr_ff[mean_idx + CSR_W'(1)]);
            default: x_ff[feat_ff] <= sat16(nprod_ff >>> 20);
         endcase
      end
      if (t1_ff.vld) begin
         if (t1_ff.kind == K_MAC_X || t1_ff.kind == K_MAC_H) begin
            p2_ff <= w_rdata * opnd;
         end else begin
            p2_ff <= 32'(w_rdata);
         end
      end
      if (t2_ff.vld) begin
         if (t2_ff.kind == K_BIAS_I) begin
            bsum_ff <= 17'(p2_ff);
         end
         acc_ff <= acc_in;
      end
      if (state_ff == S_UPD) begin
         if (sub_ff == 4'd1) begin
            c_old_ff <= filled_ff ? signed'(s_rdata[31:16]) : 16'sd0;
         end
         if (sub_ff >= 4'd1 && sub_ff <= 4'd4) begin
            gr_ff[gsel] <= g_rdata;
         end
         case (sub_ff)
            U_ACT: begin
               act_ff[0] <= pwl_sig(gr_ff[0]);
               act_ff[1] <= pwl_sig(gr_ff[1]);
               act_ff[2] <= pwl_tanh(gr_ff[2]);
               act_ff[3] <= pwl_sig(gr_ff[3]);
            end
            U_MUL: begin
               m1_ff <= act_ff[1] * c_old_ff;
               m2_ff <= act_ff[0] * act_ff[2];
            end
            U_CELL: c_new_ff <= to_q12(64'(m1_ff) + 64'(m2_ff));
            U_TANH: th_ff    <= pwl_tanh(c_new_ff);
            U_OMUL: m3_ff    <= act_ff[3] * th_ff;
            default: ;
         endcase
      end
      if (state_ff == S_DENORM) begin
         if (sub_ff == 4'd0) begin
            oprod_ff <= 64'(signed'(acc_ff[ACC_W-1:8])) * 64'(csr_ff[R_OUT_SCALE]);
         end else begin
            res_ff <= sat32((oprod_ff >>> 16) + 64'(csr_ff[R_OUT_OFFSET]));
         end
      end
      if (state_ff == S_OUT && state_in == S_IDLE) begin
         rsp_pred_ff <= res_ff;
      end
   end

   // ---------------- assertions ----------------
   a_gate_wr_phase: assert property (@(posedge clock) disable iff (reset)
      gate_we |-> (state_ff == S_GATE || state_ff == S_GDRAIN))
      else $error("gate write outside gate phase");

   a_upd_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (!t1_ff.vld && !t2_ff.vld))
      else $error("MAC lane busy during cell update");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");

endmodule
